/* rtl/core/sdr_pkg.sv */
// Package for the stream duplicate remover: widths and default table depth.
// No dependencies; imported by every module of the block.
`default_nettype none
package sdr_pkg;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 7;
    localparam int DEPTH_DEFAULT = 64;
endpackage
`default_nettype wire

/* rtl/core/sdr_if.sv */
// Stream interfaces for the duplicate remover: input element and result channels.
// Depends on sdr_pkg for field widths.
`default_nettype none
interface sdr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sdr_pkg::VALUE_W-1:0]  value;
    logic                                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sdr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sdr_pkg::VALUE_W-1:0]  value_out;
    logic                                keep;
    logic        [sdr_pkg::COUNT_W-1:0]  distinct_count;
    logic                                overflow;
    logic                                last_out;

    modport source (output valid, output value_out, output keep, output distinct_count,
                    output overflow, output last_out, input ready);
    modport sink   (input valid, input value_out, input keep, input distinct_count,
                    input overflow, input last_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/sdr_cell.sv */
// One table cell: holds a stored value, takes its neighbor's value on insert,
// and flags a match against the probe value. Depends on sdr_pkg.
`default_nettype none
module sdr_cell import sdr_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic signed [VALUE_W-1:0]  i_d,
    input  logic signed [VALUE_W-1:0]  i_probe,
    input  logic        [CW-1:0]       i_count,
    output logic signed [VALUE_W-1:0]  o_q,
    output logic                       o_hit
);
    logic signed [VALUE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_d;
        end
    end

    assign o_q   = r_value;
    assign o_hit = (CW'(IDX) < i_count) && (r_value == i_probe);
endmodule
`default_nettype wire

/* rtl/core/sdr_chain.sv */
// Row of sdr_cell instances forming the distinct-value table; newest entry at cell 0.
// Depends on sdr_pkg and sdr_cell.
`default_nettype none
module sdr_chain import sdr_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic        [CW-1:0]       i_count,
    output logic                       o_hit
);
    logic signed [VALUE_W-1:0] w_q   [DEPTH];
    logic        [DEPTH-1:0]   w_hit;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_d;
        if (g == 0) begin : g_head
            assign w_d = i_value;
        end else begin : g_body
            assign w_d = w_q[g-1];
        end
        sdr_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_d     (w_d),
            .i_probe (i_value),
            .i_count (i_count),
            .o_q     (w_q[g]),
            .o_hit   (w_hit[g])
        );
    end

    assign o_hit = |w_hit;
endmodule
`default_nettype wire

/* rtl/core/stream_duplicate_remover_unit.sv */
// Stream duplicate remover: keeps each value's first occurrence per list while the table has room.
// The result is registered and appears in the cycle after the input transaction;
// throughput: 1 transaction per cycle while results are taken, set by the combinational
// match across all table cells. Reset clears the stored count, the overflow flag and
// the result valid; the table contents are not cleared. Depends on sdr_pkg, sdr_if, sdr_chain.
`default_nettype none
module stream_duplicate_remover_unit import sdr_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdr_in_if.sink        i_in,
    sdr_out_if.source     o_out
);
    localparam int CW = $clog2(DEPTH + 1);

    logic                       w_accept;
    logic                       w_hit;
    logic                       w_full;
    logic                       w_shift;
    logic [CW-1:0]              n_count_res;
    logic                       n_ovf_res;
    logic [CW+COUNT_W-1:0]      w_count_ext;

    logic [CW-1:0]              r_count;
    logic                       r_ovf;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_value_out;
    logic                       r_keep;
    logic [COUNT_W-1:0]         r_distinct;
    logic                       r_overflow;
    logic                       r_last_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_shift    = w_accept && !w_hit && !w_full;

    sdr_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_shift (w_shift),
        .i_value (i_in.value),
        .i_count (r_count),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_count_res = r_count;
        n_ovf_res   = r_ovf;
        if (!w_hit) begin
            if (w_full) begin
                n_ovf_res = 1'b1;
            end else begin
                n_count_res = r_count + 1'b1;
            end
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, n_count_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                if (i_in.last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= n_count_res;
                    r_ovf   <= n_ovf_res;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value_out <= i_in.value;
            r_keep      <= !w_hit;
            r_distinct  <= w_count_ext[COUNT_W-1:0];
            r_overflow  <= n_ovf_res;
            r_last_out  <= i_in.last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value_out      = r_value_out;
    assign o_out.keep           = r_keep;
    assign o_out.distinct_count = r_distinct;
    assign o_out.overflow       = r_overflow;
    assign o_out.last_out       = r_last_out;
endmodule
`default_nettype wire

/* rtl/core/sdr_checker.sv */
// Port-level checks for stream_duplicate_remover_unit, attached by bind.
// Depends on sdr_pkg and the top level's interface ports.
`default_nettype none
module sdr_checker import sdr_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic signed [VALUE_W-1:0]  i_value_out,
    input logic                       i_keep,
    input logic [COUNT_W-1:0]         i_distinct,
    input logic                       i_overflow
);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("transaction accepted without a result next cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_value_out)))
        else $error("stalled result changed");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_overflow) |-> (i_distinct == FULL_COUNT))
        else $error("overflow reported with table not full");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_keep) |-> (i_distinct != '0))
        else $error("duplicate reported with empty table");
endmodule

bind stream_duplicate_remover_unit sdr_checker #(
    .DEPTH (DEPTH)
) u_sdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_value_out (o_out.value_out),
    .i_keep      (o_out.keep),
    .i_distinct  (o_out.distinct_count),
    .i_overflow  (o_out.overflow)
);
`default_nettype wire
